// ===== rtl/core/idjd_pkg.sv =====
// Shared types and constants of the idle-device job dispatcher.
package idjd_pkg;

    localparam int MODEL_W     = 4;
    localparam int REQ_W       = 3;
    localparam int MASK_W      = 4;
    localparam int DEV_W       = 2;
    localparam int KIND_W      = 2;
    localparam int ENTRY_W     = MODEL_W + REQ_W;
    localparam int MAP_W       = 32;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    localparam logic ACT_ENQ   = 1'b0;
    localparam logic ACT_SCHED = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ENQ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DISP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;

    typedef struct packed {
        logic enq;
        logic start;
        logic walk;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic walk_done;
    } t_sts;

endpackage

// ===== rtl/core/idjd_ctrl.sv =====
// Control state machine of the idle-device job dispatcher.
module idjd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_accept,
    input  logic               i_action,
    input  idjd_pkg::t_sts     i_sts,
    output idjd_pkg::t_cmd     o_cmd,
    output logic               o_ready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    t_state r_state;

    always_comb begin
        o_ready      = (r_state == S_IDLE) && i_sts.out_free;
        o_cmd.enq    = i_in_accept && (i_action == idjd_pkg::ACT_ENQ);
        o_cmd.start  = i_in_accept && (i_action == idjd_pkg::ACT_SCHED);
        o_cmd.walk   = (r_state == S_WALK);
        o_cmd.finish = (r_state == S_DONE) && i_sts.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.start) begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (i_sts.walk_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.enq, o_cmd.start, o_cmd.walk, o_cmd.finish}))
        else $error("More than one datapath command in one cycle.");

    a_start_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == S_WALK) && !o_ready)
        else $error("A schedule request did not begin a walk.");

endmodule

// ===== rtl/core/idjd_datapath.sv =====
// Job queue memory, walk pointers, pending dispatch and output register.
module idjd_datapath #(
    parameter int QUEUE_DEPTH = 16,
    parameter int NUM_DEVICES = 4,
    parameter int NUM_MODELS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  idjd_pkg::t_cmd                      i_cmd,
    output idjd_pkg::t_sts                      o_sts,
    input  logic                                i_cfg_valid,
    input  logic [idjd_pkg::MAP_W-1:0]          i_cfg_data,
    input  logic [idjd_pkg::MODEL_W-1:0]        i_model,
    input  logic [idjd_pkg::REQ_W-1:0]          i_req,
    input  logic [idjd_pkg::MASK_W-1:0]         i_idle,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [idjd_pkg::KIND_W-1:0]         o_kind,
    output logic                                o_acc,
    output logic [idjd_pkg::DEV_W-1:0]          o_dev,
    output logic [idjd_pkg::MODEL_W-1:0]        o_model,
    output logic [idjd_pkg::REQ_W-1:0]          o_req,
    output logic                                o_last
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [idjd_pkg::MASK_W-1:0] DevMask =
        (NUM_DEVICES >= idjd_pkg::MASK_W) ? {idjd_pkg::MASK_W{1'b1}}
                                          : idjd_pkg::MASK_W'((1 << NUM_DEVICES) - 1);

    logic [idjd_pkg::ENTRY_W-1:0] mem [QUEUE_DEPTH];

    logic [idjd_pkg::MAP_W-1:0]   r_map;
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                r_rd;
    logic [CW-1:0]                r_wr;
    logic                         r_ev;
    logic [idjd_pkg::ENTRY_W-1:0] r_rdata;
    logic [idjd_pkg::MASK_W-1:0]  r_mask;
    logic                         r_pv;
    logic [idjd_pkg::DEV_W-1:0]   r_pdev;
    logic [idjd_pkg::MODEL_W-1:0] r_pmodel;
    logic [idjd_pkg::REQ_W-1:0]   r_preq;
    logic                         r_ov;

    logic [idjd_pkg::MODEL_W-1:0] e_model;
    logic [idjd_pkg::REQ_W-1:0]   e_req;
    logic [2:0]                   tgt;
    logic                         hit;
    logic                         full;
    logic                         out_take;
    logic                         out_free;
    logic                         stall;
    logic                         step;
    logic                         proc;
    logic                         issue;
    logic                         push;
    logic                         keep;
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [idjd_pkg::ENTRY_W-1:0] mem_wdata;

    always_comb begin
        e_model = r_rdata[idjd_pkg::ENTRY_W-1:idjd_pkg::REQ_W];
        e_req   = r_rdata[idjd_pkg::REQ_W-1:0];
        if ({1'b0, e_req} < 4'(NUM_DEVICES)) begin
            tgt = e_req;
        end else if ({1'b0, e_model} < 5'(NUM_MODELS)) begin
            tgt = {1'b0, r_map[{e_model, 1'b0} +: 2]};
        end else begin
            tgt = 3'd0;
        end
        hit       = !tgt[2] && r_mask[tgt[1:0]];
        full      = (r_count == CW'(QUEUE_DEPTH));
        out_take  = r_ov && i_out_ready;
        out_free  = !r_ov || out_take;
        stall     = r_ev && hit && r_pv && !out_free;
        step      = i_cmd.walk && !stall;
        proc      = step && r_ev;
        issue     = step && (r_rd != r_count);
        push      = proc && hit && r_pv;
        keep      = proc && !hit;
        mem_we    = (i_cmd.enq && !full) || keep;
        mem_waddr = i_cmd.enq ? r_count[AW-1:0] : r_wr[AW-1:0];
        mem_wdata = i_cmd.enq ? {i_model, i_req} : r_rdata;
        o_sts.out_free  = out_free;
        o_sts.walk_done = !r_ev && (r_rd == r_count);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (issue) begin
            r_rdata <= mem[r_rd[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map   <= '0;
            r_count <= '0;
            r_rd    <= '0;
            r_wr    <= '0;
            r_ev    <= 1'b0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_map <= i_cfg_data;
            end
            if (i_cmd.enq && !full) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.finish) begin
                r_count <= r_wr;
            end
            if (i_cmd.start) begin
                r_rd <= '0;
                r_wr <= '0;
                r_ev <= 1'b0;
                r_pv <= 1'b0;
            end else begin
                if (issue) begin
                    r_rd <= r_rd + CW'(1);
                end
                if (keep) begin
                    r_wr <= r_wr + CW'(1);
                end
                if (step) begin
                    r_ev <= issue;
                end
                if (proc && hit) begin
                    r_pv <= 1'b1;
                end else if (i_cmd.finish) begin
                    r_pv <= 1'b0;
                end
            end
            if (i_cmd.enq || push || i_cmd.finish) begin
                r_ov <= 1'b1;
            end else if (out_take) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mask <= i_idle & DevMask;
        end else if (proc && hit) begin
            r_mask[tgt[1:0]] <= 1'b0;
        end
        if (proc && hit) begin
            r_pdev   <= tgt[1:0];
            r_pmodel <= e_model;
            r_preq   <= e_req;
        end
        if (i_cmd.enq) begin
            o_kind  <= idjd_pkg::KIND_ENQ;
            o_acc   <= !full;
            o_dev   <= '0;
            o_model <= '0;
            o_req   <= '0;
            o_last  <= 1'b1;
        end else if (push || (i_cmd.finish && r_pv)) begin
            o_kind  <= idjd_pkg::KIND_DISP;
            o_acc   <= 1'b0;
            o_dev   <= r_pdev;
            o_model <= r_pmodel;
            o_req   <= r_preq;
            o_last  <= i_cmd.finish;
        end else if (i_cmd.finish) begin
            o_kind  <= idjd_pkg::KIND_NONE;
            o_acc   <= 1'b0;
            o_dev   <= '0;
            o_model <= '0;
            o_req   <= '0;
            o_last  <= 1'b1;
        end
    end

    assign o_out_valid = r_ov;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("Job count exceeds the queue depth.");

    a_write_behind_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev |-> (r_wr < r_rd))
        else $error("Compaction write pointer caught up with the read pointer.");

    a_pending_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> !r_mask[r_pdev])
        else $error("Pending job's device is still marked idle.");

endmodule

// ===== rtl/core/idle_device_job_dispatcher.sv =====
// Top level of the idle-device job dispatcher.
// An enqueue request is answered in the cycle right after it is accepted, so its result
// can be taken at the next clock edge. The answer has accepted low when the queue already
// holds QUEUE_DEPTH jobs. Enqueue requests can follow back to back while the result side
// keeps up. A schedule request walks the queue from its head. It reads one stored job per
// cycle from the queue memory, except while a dispatch waits for the result side, and
// writes kept jobs back toward the head, compacting the queue. The next request is taken
// at the earliest in the cycle in which its final result is taken. Each dispatched job
// gives one result, with the final one marked by tlast. A schedule request that dispatches
// nothing gives a single result. The queue memory needs no clearing after reset.
module idle_device_job_dispatcher #(
    parameter int QUEUE_DEPTH = 16,
    parameter int NUM_DEVICES = 4,
    parameter int NUM_MODELS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // model [3:0], requested device [6:4], idle mask [10:7], zeros above.
    input  logic [idjd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // action [0].
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // accepted [0], device [2:1], job_model [6:3], job_request [9:7], zeros above.
    output logic [idjd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // kind [1:0].
    output logic [idjd_pkg::KIND_W-1:0]         m_axis_tuser,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [idjd_pkg::MAP_W-1:0]          i_cfg_data
);

    idjd_pkg::t_cmd cmd;
    idjd_pkg::t_sts sts;
    logic           in_accept;
    logic           out_acc;
    logic [idjd_pkg::DEV_W-1:0]   out_dev;
    logic [idjd_pkg::MODEL_W-1:0] out_model;
    logic [idjd_pkg::REQ_W-1:0]   out_req;

    assign in_accept   = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    idjd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (in_accept),
        .i_action    (s_axis_tuser),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_ready     (s_axis_tready)
    );

    idjd_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_DEVICES (NUM_DEVICES),
        .NUM_MODELS  (NUM_MODELS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_model     (s_axis_tdata[3:0]),
        .i_req       (s_axis_tdata[6:4]),
        .i_idle      (s_axis_tdata[10:7]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_kind      (m_axis_tuser),
        .o_acc       (out_acc),
        .o_dev       (out_dev),
        .o_model     (out_model),
        .o_req       (out_req),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, out_req, out_model, out_dev, out_acc};

endmodule

// ===== tb/idle_device_job_dispatcher_tb.sv =====
// Self-checking testbench of the idle-device job dispatcher: directed table, then random requests.
`timescale 1ns / 1ps

module idle_device_job_dispatcher_tb;

    localparam int JOB_SLOTS = 16;
    localparam int PHASES    = 5;
    localparam int PHASE_LEN = 46;
    localparam int DIR_ROWS  = 13;

    typedef struct packed {
        logic [idjd_pkg::KIND_W-1:0]  kind;
        logic                         accepted;
        logic [idjd_pkg::DEV_W-1:0]   device;
        logic [idjd_pkg::MODEL_W-1:0] job_model;
        logic [idjd_pkg::REQ_W-1:0]   job_request;
        logic                         last;
    } t_disp_result;

    typedef struct packed {
        logic [idjd_pkg::MODEL_W-1:0] model;
        logic [idjd_pkg::REQ_W-1:0]   request;
    } t_queued_job;

    typedef struct {
        logic                         act;
        logic [idjd_pkg::MODEL_W-1:0] mdl;
        logic [idjd_pkg::REQ_W-1:0]   req;
        logic [idjd_pkg::MASK_W-1:0]  idle;
        int                           reps;
        logic                         typed;
        t_disp_result                 answer;
    } t_stim_row;

    localparam t_disp_result ENQ_TAKEN    =
        '{idjd_pkg::KIND_ENQ, 1'b1, 2'd0, 4'd0, 3'd0, 1'b1};
    localparam t_disp_result ENQ_REFUSED  =
        '{idjd_pkg::KIND_ENQ, 1'b0, 2'd0, 4'd0, 3'd0, 1'b1};
    localparam t_disp_result NOTHING_SENT =
        '{idjd_pkg::KIND_NONE, 1'b0, 2'd0, 4'd0, 3'd0, 1'b1};
    localparam t_disp_result NO_ANSWER    = '0;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    logic [idjd_pkg::IN_TDATA_W-1:0]     s_axis_tdata;
    logic                                s_axis_tuser;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [idjd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
    logic [idjd_pkg::KIND_W-1:0]         m_axis_tuser;
    logic                                m_axis_tlast;
    logic                                i_cfg_valid;
    logic                                o_cfg_ready;
    logic [idjd_pkg::MAP_W-1:0]          i_cfg_data;

    logic [idjd_pkg::MAP_W-1:0] dev_map;
    t_queued_job                job_list[$];
    t_disp_result               predicted[$];
    t_disp_result               awaited_results[$];
    int                         err_count = 0;
    int                         burst_left;
    t_stim_row                  dir_rows[DIR_ROWS];
    logic [idjd_pkg::MAP_W-1:0] map_settings[PHASES];
    int                         enq_percent[PHASES];

    bit               hold_req;
    bit               hold_done  = 1'b0;
    int               hold_left  = 0;
    int               rx_cycle   = 0;
    int               rx_mode    = 0;
    logic [7:0]       rx_pattern = 8'b1101_0110;

    idle_device_job_dispatcher DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [idjd_pkg::DEV_W-1:0] target_device(input t_queued_job job);
        if (job.request < 3'd4) begin
            return job.request[idjd_pkg::DEV_W-1:0];
        end
        return dev_map[2*job.model +: 2];
    endfunction

    task automatic predict_dispatch(input logic act,
                                    input logic [idjd_pkg::MODEL_W-1:0] mdl,
                                    input logic [idjd_pkg::REQ_W-1:0] req,
                                    input logic [idjd_pkg::MASK_W-1:0] idle);
        t_queued_job                 kept[$];
        logic [idjd_pkg::MASK_W-1:0] free_mask;
        logic [idjd_pkg::DEV_W-1:0]  dev;
        predicted.delete();
        if (act == idjd_pkg::ACT_ENQ) begin
            if (job_list.size() < JOB_SLOTS) begin
                job_list.insert(job_list.size(), '{mdl, req});
                predicted.insert(predicted.size(), ENQ_TAKEN);
            end else begin
                predicted.insert(predicted.size(), ENQ_REFUSED);
            end
        end else begin
            free_mask = idle;
            foreach (job_list[i]) begin
                dev = target_device(job_list[i]);
                if (free_mask != '0 && free_mask[dev]) begin
                    free_mask[dev] = 1'b0;
                    predicted.insert(predicted.size(),
                                     '{idjd_pkg::KIND_DISP, 1'b0, dev, job_list[i].model,
                                       job_list[i].request, 1'b0});
                end else begin
                    kept.insert(kept.size(), job_list[i]);
                end
            end
            job_list = kept;
            if (predicted.size() == 0) begin
                predicted.insert(0, NOTHING_SENT);
            end else begin
                predicted[predicted.size()-1].last = 1'b1;
            end
        end
    endtask

    task automatic offer_request(input logic act, input logic [idjd_pkg::MODEL_W-1:0] mdl,
                                 input logic [idjd_pkg::REQ_W-1:0] req,
                                 input logic [idjd_pkg::MASK_W-1:0] idle,
                                 input logic typed, input t_disp_result answer);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {5'd0, idle, req, mdl};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
        predict_dispatch(act, mdl, req, idle);
        if (typed) begin
            awaited_results.insert(awaited_results.size(), answer);
        end else begin
            foreach (predicted[i]) begin
                awaited_results.insert(awaited_results.size(), predicted[i]);
            end
        end
    endtask

    task automatic write_device_map(input logic [idjd_pkg::MAP_W-1:0] value);
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        dev_map = value;
    endtask

    task automatic compare_field(input string fname, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_disp_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: result with none expected, actual tuser %0d tdata %h",
                         $time, m_axis_tuser, m_axis_tdata);
                err_count++;
            end else begin
                want = awaited_results.pop_front();
                compare_field("kind", 32'(want.kind), 32'(m_axis_tuser));
                compare_field("accepted", 32'(want.accepted), 32'(m_axis_tdata[0]));
                compare_field("device", 32'(want.device), 32'(m_axis_tdata[2:1]));
                compare_field("job_model", 32'(want.job_model), 32'(m_axis_tdata[6:3]));
                compare_field("job_request", 32'(want.job_request), 32'(m_axis_tdata[9:7]));
                compare_field("last", 32'(want.last), 32'(m_axis_tlast));
            end
        end
    end

    // The result side switches at random among stall modes; a hold request parks it for a long stretch.
    always @(posedge i_clk) begin
        rx_cycle++;
        if (rx_cycle % 97 == 0) begin
            rx_mode = $urandom_range(0, 3);
        end
        rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 200;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: begin
                    m_axis_tready <= 1'b1;
                end
                1: begin
                    m_axis_tready <= ($urandom_range(0, 9) < 7);
                end
                2: begin
                    m_axis_tready <= rx_pattern[0];
                end
                default: begin
                    m_axis_tready <= ($urandom_range(0, 9) < 3);
                end
            endcase
        end
    end

    initial begin
        #3_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        logic [idjd_pkg::MASK_W-1:0] idle;
        logic                        act;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        burst_left    = 0;
        hold_req      = 1'b0;
        dev_map       = '0;

        dir_rows = '{
            '{idjd_pkg::ACT_SCHED, 4'd0,  3'd0, 4'hF, 1,  1'b1, NOTHING_SENT},
            '{idjd_pkg::ACT_ENQ,   4'd0,  3'd7, 4'h0, 1,  1'b1, ENQ_TAKEN},
            '{idjd_pkg::ACT_ENQ,   4'd15, 3'd4, 4'hF, 1,  1'b1, ENQ_TAKEN},
            '{idjd_pkg::ACT_ENQ,   4'd3,  3'd2, 4'h5, 1,  1'b1, ENQ_TAKEN},
            '{idjd_pkg::ACT_ENQ,   4'd5,  3'd3, 4'hA, 1,  1'b1, ENQ_TAKEN},
            '{idjd_pkg::ACT_SCHED, 4'd15, 3'd7, 4'h0, 1,  1'b1, NOTHING_SENT},
            '{idjd_pkg::ACT_SCHED, 4'd0,  3'd0, 4'h2, 1,  1'b1, NOTHING_SENT},
            '{idjd_pkg::ACT_SCHED, 4'd0,  3'd0, 4'hD, 1,  1'b0, NO_ANSWER},
            '{idjd_pkg::ACT_ENQ,   4'd9,  3'd1, 4'h3, 15, 1'b1, ENQ_TAKEN},
            '{idjd_pkg::ACT_ENQ,   4'd15, 3'd7, 4'hF, 2,  1'b1, ENQ_REFUSED},
            '{idjd_pkg::ACT_SCHED, 4'd0,  3'd0, 4'hF, 1,  1'b0, NO_ANSWER},
            '{idjd_pkg::ACT_ENQ,   4'd6,  3'd6, 4'h0, 1,  1'b1, ENQ_TAKEN},
            '{idjd_pkg::ACT_SCHED, 4'd8,  3'd5, 4'hF, 1,  1'b0, NO_ANSWER}
        };
        map_settings = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hE4E4_E4E4, $urandom, $urandom};
        enq_percent  = '{75, 50, 40, 65, 55};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The map keeps its reset value through the directed table.
        foreach (dir_rows[r]) begin
            repeat (dir_rows[r].reps) begin
                offer_request(dir_rows[r].act, dir_rows[r].mdl, dir_rows[r].req,
                              dir_rows[r].idle, dir_rows[r].typed, dir_rows[r].answer);
            end
        end
        s_axis_tvalid <= 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            write_device_map(map_settings[ph]);
            if (ph == 1) begin
                hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_LEN; n++) begin
                act  = ($urandom_range(0, 99) < enq_percent[ph]) ? idjd_pkg::ACT_ENQ
                                                                 : idjd_pkg::ACT_SCHED;
                idle = idjd_pkg::MASK_W'($urandom_range(0, 15));
                offer_request(act, idjd_pkg::MODEL_W'($urandom_range(0, 15)),
                              idjd_pkg::REQ_W'($urandom_range(0, 7)), idle,
                              1'b0, NO_ANSWER);
            end
            s_axis_tvalid <= 1'b0;
        end

        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
